// ----- sv/btlv_pkg.sv -----
// Shared types and defaults for the BER-TLV header decoder.
`default_nettype none
package btlv_pkg;

  localparam int TAG_MAX_BYTES_DEF = 4;
  localparam int LEN_BYTES_DEF     = 4;

  localparam int TDATA_W = 72;

  typedef enum logic [3:0] {
    PH_TAG_FIRST = 4'b0001,
    PH_TAG_MORE  = 4'b0010,
    PH_LEN_FIRST = 4'b0100,
    PH_LEN_MORE  = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO_TAG = 3'd1,
    ST_TAG_LONG = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_INDEF    = 3'd4,
    ST_LEN_LONG = 3'd5
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  header_bytes;
    logic [31:0] length_value;
    logic [31:0] tag_value;
  } result_t;

endpackage
`default_nettype wire

// ----- sv/ber_tlv_header_decoder_top.sv -----
// Top level of the BER-TLV header decoder: input register, decode core, result register.
//
// Usage: header bytes enter one per request on the s_ channel (s_tdata holds the
// byte, s_tlast marks the last byte left in the buffer). When a tag and length
// have been decoded, or decoding fails, one result leaves on the m_ channel with
// the tag, the length, the header byte count and a status code. Bytes that do
// not end a header produce no output.
// Path: the byte that ends the header is accepted into the input register, then its
// result is captured by the result register, which raises m_tvalid; a stall on
// m_tready can hold that byte in the input register between the two.
// Throughput: one byte per cycle while no result is held back by m_tready; the decode
// step between the two registers is a single shift, merge and a few small compares.
// Reset: rst clears the decode state to expect a first tag byte and empties both
// registers.
// Stall: while m_tready is low and a result is held, the input register stops
// advancing and s_tready drops once it is full; nothing is lost or repeated.
`default_nettype none
module ber_tlv_header_decoder_top #(
  parameter int TAG_MAX_BYTES = btlv_pkg::TAG_MAX_BYTES_DEF,
  parameter int LEN_BYTES     = btlv_pkg::LEN_BYTES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // data_byte[7:0]
  input  wire logic [7:0]                   s_tdata,
  input  wire logic                         s_tlast,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // tag_value[31:0], length_value[63:32], header_bytes[67:64], status[70:68], zero[71]
  output logic [btlv_pkg::TDATA_W-1:0]      m_tdata
);
  import btlv_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       can_take;
  logic       step;
  logic       res_valid;
  result_t    res;

  // The held byte is decoded only when the result register can take its result.
  assign step     = in_valid && can_take;
  assign s_tready = !in_valid || can_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  btlv_core #(
    .TAG_MAX_BYTES(TAG_MAX_BYTES),
    .LEN_BYTES    (LEN_BYTES)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .data_byte      (in_byte),
    .last_available (in_last),
    .res_valid      (res_valid),
    .res            (res)
  );

  btlv_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .can_take  (can_take),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
`default_nettype wire

// ----- sv/btlv_core.sv -----
// Decode state and per-byte step logic for tag and length parsing.
`default_nettype none
module btlv_core #(
  parameter int TAG_MAX_BYTES = btlv_pkg::TAG_MAX_BYTES_DEF,
  parameter int LEN_BYTES     = btlv_pkg::LEN_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [7:0]       data_byte,
  input  wire logic             last_available,
  output logic                  res_valid,
  output btlv_pkg::result_t     res
);
  import btlv_pkg::*;

  localparam logic [4:0] TagMultiMask = 5'h1f;
  localparam logic [3:0] TagMax = 4'(TAG_MAX_BYTES);
  localparam logic [6:0] LenMax = 7'(LEN_BYTES);

  phase_t      phase, phase_next;
  logic [31:0] tag_accum, tag_accum_next;
  logic [3:0]  tag_count, tag_count_next;
  logic [31:0] length_accum, length_accum_next;
  logic [3:0]  length_left, length_left_next;
  logic [3:0]  byte_total, byte_total_next;

  logic        done;
  status_t     st;
  logic [6:0]  len_count;

  always_comb begin
    phase_next        = phase;
    tag_accum_next    = tag_accum;
    tag_count_next    = tag_count;
    length_accum_next = length_accum;
    length_left_next  = length_left;
    byte_total_next   = (byte_total != 4'hf) ? byte_total + 4'd1 : byte_total;
    done              = 1'b0;
    st                = ST_OK;
    len_count         = data_byte[6:0];

    case (phase)
      PH_TAG_FIRST: begin
        tag_accum_next = {24'd0, data_byte};
        tag_count_next = 4'd1;
        if (data_byte == 8'd0) begin
          done = 1'b1;
          st   = ST_ZERO_TAG;
        end else if (data_byte[4:0] != TagMultiMask) begin
          if (last_available) begin
            done = 1'b1;
            st   = ST_TRUNC;
          end else begin
            phase_next = PH_LEN_FIRST;
          end
        end else if (last_available) begin
          done = 1'b1;
          st   = ST_TRUNC;
        end else if (tag_count_next >= TagMax) begin
          done = 1'b1;
          st   = ST_TAG_LONG;
        end else begin
          phase_next = PH_TAG_MORE;
        end
      end
      PH_TAG_MORE: begin
        tag_accum_next = {tag_accum[23:0], data_byte};
        tag_count_next = (tag_count != 4'hf) ? tag_count + 4'd1 : tag_count;
        if (last_available) begin
          // Both outcomes need another byte: more tag, or the length.
          done = 1'b1;
          st   = ST_TRUNC;
        end else if (data_byte[7]) begin
          if (tag_count_next >= TagMax) begin
            done = 1'b1;
            st   = ST_TAG_LONG;
          end else begin
            phase_next = PH_TAG_MORE;
          end
        end else begin
          phase_next = PH_LEN_FIRST;
        end
      end
      PH_LEN_FIRST: begin
        if (!data_byte[7]) begin
          length_accum_next = {25'd0, data_byte[6:0]};
          done              = 1'b1;
          st                = ST_OK;
        end else if (len_count == 7'd0) begin
          done = 1'b1;
          st   = ST_INDEF;
        end else if (last_available) begin
          done = 1'b1;
          st   = ST_TRUNC;
        end else if (len_count > LenMax) begin
          done = 1'b1;
          st   = ST_LEN_LONG;
        end else begin
          length_accum_next = 32'd0;
          length_left_next  = len_count[3:0];
          phase_next        = PH_LEN_MORE;
        end
      end
      PH_LEN_MORE: begin
        length_accum_next = {length_accum[23:0], data_byte};
        length_left_next  = (length_left != 4'd0) ? length_left - 4'd1 : length_left;
        if (length_left_next == 4'd0) begin
          done = 1'b1;
          st   = ST_OK;
        end else if (last_available) begin
          done = 1'b1;
          st   = ST_TRUNC;
        end
      end
      default: begin
        phase_next = PH_TAG_FIRST;
      end
    endcase

    res.tag_value    = tag_accum_next;
    res.length_value = (st == ST_OK) ? length_accum_next : 32'd0;
    res.header_bytes = byte_total_next;
    res.status       = st;
    res_valid        = step && done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_TAG_FIRST;
      tag_accum    <= 32'd0;
      tag_count    <= 4'd0;
      length_accum <= 32'd0;
      length_left  <= 4'd0;
      byte_total   <= 4'd0;
    end else if (step) begin
      if (done) begin
        phase        <= PH_TAG_FIRST;
        tag_accum    <= 32'd0;
        tag_count    <= 4'd0;
        length_accum <= 32'd0;
        length_left  <= 4'd0;
        byte_total   <= 4'd0;
      end else begin
        phase        <= phase_next;
        tag_accum    <= tag_accum_next;
        tag_count    <= tag_count_next;
        length_accum <= length_accum_next;
        length_left  <= length_left_next;
        byte_total   <= byte_total_next;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/btlv_out_reg.sv -----
// Result register that holds one decoded header for the output stream.
`default_nettype none
module btlv_out_reg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              res_valid,
  input  wire btlv_pkg::result_t                 res,
  output logic                                   can_take,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // tag_value[31:0], length_value[63:32], header_bytes[67:64], status[70:68], zero[71]
  output logic [btlv_pkg::TDATA_W-1:0]           m_tdata
);
  import btlv_pkg::*;

  result_t held;

  assign can_take = !m_tvalid || m_tready;
  assign m_tdata  = {1'b0, held.status, held.header_bytes, held.length_value,
                     held.tag_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (can_take) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && res_valid) begin
      held <= res;
    end
  end

endmodule
`default_nettype wire
